// ----- hw/rtl/zpconv_pkg.sv -----
// Shared types, codes and constants of the zero-padded 2D convolution block.
package zpconv_pkg;

  // Default store sizes, handed to the top-level parameters.
  localparam int MAX_IMAGE_DIM_DEF  = 64;
  localparam int MAX_KERNEL_DIM_DEF = 8;
  localparam int SAMPLE_BITS_DEF    = 16;

  // Fixed field widths.
  localparam int COORD_W    = 6;
  localparam int VALUE_W    = 16;
  localparam int PIXEL_W    = 32;
  localparam int CFG_DIM_W  = 7;
  localparam int CFG_KDIM_W = 4;
  localparam int CFG_FRAC_W = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;
  localparam int ACC_W      = 64;

  // Request kinds.
  localparam logic [1:0] KIND_KERNEL  = 2'd0;
  localparam logic [1:0] KIND_IMAGE   = 2'd1;
  localparam logic [1:0] KIND_COMPUTE = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_FRAC   = 3'd4;

  // Register reset values.
  localparam logic [CFG_DIM_W-1:0]  RST_IMAGE_WIDTH   = 7'd64;
  localparam logic [CFG_DIM_W-1:0]  RST_IMAGE_HEIGHT  = 7'd64;
  localparam logic [CFG_KDIM_W-1:0] RST_KERNEL_WIDTH  = 4'd3;
  localparam logic [CFG_KDIM_W-1:0] RST_KERNEL_HEIGHT = 4'd3;
  localparam logic [CFG_FRAC_W-1:0] RST_KERNEL_FRAC   = 4'd8;

  typedef struct packed {
    logic [1:0]                kind;
    logic [COORD_W-1:0]        col;
    logic [COORD_W-1:0]        row;
    logic signed [VALUE_W-1:0] value;
  } zpconv_in_t;

  typedef struct packed {
    logic [COORD_W-1:0]        out_col;
    logic [COORD_W-1:0]        out_row;
    logic signed [PIXEL_W-1:0] pixel_out;
    logic                      saturated;
  } zpconv_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH0,
    ST_FLUSH1,
    ST_SCALE
  } zpconv_state_t;

endpackage

// ----- hw/rtl/zero_padded_2d_convolution.sv -----
// Top level of the zero-padded, same-size 2D convolution block.
//
// A request is taken at a rising edge where start is high and busy is low.
// Kernel and image writes go into the stores at the accepting edge and busy
// stays low, so while busy is low a stream of writes runs at one per clock;
// writes outside the sizes in use are dropped. A query for a pixel outside
// the image gives its result, with a zero pixel, in the cycle after it was
// taken and also leaves busy low. A query inside the image raises busy while
// the sequencer passes through its ST_RUN, ST_FLUSH0, ST_FLUSH1 and ST_SCALE
// states, and its result strobe follows ST_SCALE. Its length is set by the single
// multiply-accumulate unit, which takes one kernel tap per clock from the
// two store memories, plus the read, multiply and scaling stages behind it.
// The result is shown for exactly one cycle with out_valid high: the
// receiver cannot stall, so it must take every result as it appears.
// Configuration writes are always accepted, but should only be made while
// the block is idle.
module zero_padded_2d_convolution #(
  parameter int MAX_IMAGE_DIM  = zpconv_pkg::MAX_IMAGE_DIM_DEF,
  parameter int MAX_KERNEL_DIM = zpconv_pkg::MAX_KERNEL_DIM_DEF,
  parameter int SAMPLE_BITS    = zpconv_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // Request channel.
  input  logic                                   start,
  output logic                                   busy,
  input  zpconv_pkg::zpconv_in_t                 in_data,
  // Result channel.
  output logic                                   out_valid,
  output zpconv_pkg::zpconv_out_t                out_data,
  // Configuration channel.
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [zpconv_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [zpconv_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // Store geometry.
  localparam int IDEPTH = MAX_IMAGE_DIM * MAX_IMAGE_DIM;
  localparam int KDEPTH = MAX_KERNEL_DIM * MAX_KERNEL_DIM;
  localparam int IAW    = (IDEPTH > 1) ? $clog2(IDEPTH) : 1;
  localparam int KAW    = (KDEPTH > 1) ? $clog2(KDEPTH) : 1;
  // Widths that hold the clamped sizes themselves.
  localparam int IDW    = $clog2(MAX_IMAGE_DIM + 1);
  localparam int KCW    = $clog2(MAX_KERNEL_DIM + 1);
  // Signed width of a tap's image coordinate, which may fall below zero or
  // beyond the image by up to a kernel size.
  localparam int XW     = $clog2((1 << zpconv_pkg::CFG_DIM_W) + MAX_KERNEL_DIM) + 1;
  localparam int PW     = 2 * SAMPLE_BITS;
  localparam int AW     = zpconv_pkg::ACC_W;
  localparam int QW     = zpconv_pkg::PIXEL_W;

  // Configuration registers.
  logic [zpconv_pkg::CFG_DIM_W-1:0]  image_width_r, image_height_r;
  logic [zpconv_pkg::CFG_KDIM_W-1:0] kernel_width_r, kernel_height_r;
  logic [zpconv_pkg::CFG_FRAC_W-1:0] kernel_frac_r;

  // Sequencer and datapath registers.
  zpconv_pkg::zpconv_state_t state_r, state_nxt;
  logic [KCW-1:0]                    tap_l_r, tap_l_nxt, tap_k_r, tap_k_nxt;
  logic [zpconv_pkg::COORD_W-1:0]    q_col_r, q_row_r;
  logic                              rd_valid_r, prod_valid_r;
  logic signed [PW-1:0]              prod_r;
  logic signed [AW-1:0]              acc_r, acc_nxt;
  logic                              out_valid_r;
  zpconv_pkg::zpconv_out_t           out_data_r, out_data_nxt;

  // Combinational signals.
  logic [IDW-1:0]           iw_eff, ih_eff;
  logic [KCW-1:0]           kw_eff, kh_eff;
  logic                     accept, is_compute, query_inside;
  logic                     ker_we, img_we;
  logic [SAMPLE_BITS-1:0]   wr_sample;
  logic [IAW-1:0]           img_waddr, img_raddr;
  logic [KAW-1:0]           ker_waddr, ker_raddr;
  logic [SAMPLE_BITS-1:0]   img_rdata, ker_rdata;
  logic signed [XW-1:0]     tap_x, tap_y;
  logic                     tap_inside, last_tap;
  logic                     tap_issue, load_result;
  logic signed [AW-1:0]     prod_ext, sum;
  logic                     sum_ovf;
  logic signed [AW-1:0]     scaled;
  logic                     scaled_fits;

  // A size register that holds zero acts as one; any value above the store size
  // acts as the store size.
  always_comb begin
    if (image_width_r == '0) begin
      iw_eff = IDW'(1);
    end else if (int'(image_width_r) > MAX_IMAGE_DIM) begin
      iw_eff = IDW'(MAX_IMAGE_DIM);
    end else begin
      iw_eff = IDW'(image_width_r);
    end
    if (image_height_r == '0) begin
      ih_eff = IDW'(1);
    end else if (int'(image_height_r) > MAX_IMAGE_DIM) begin
      ih_eff = IDW'(MAX_IMAGE_DIM);
    end else begin
      ih_eff = IDW'(image_height_r);
    end
    if (kernel_width_r == '0) begin
      kw_eff = KCW'(1);
    end else if (int'(kernel_width_r) > MAX_KERNEL_DIM) begin
      kw_eff = KCW'(MAX_KERNEL_DIM);
    end else begin
      kw_eff = KCW'(kernel_width_r);
    end
    if (kernel_height_r == '0) begin
      kh_eff = KCW'(1);
    end else if (int'(kernel_height_r) > MAX_KERNEL_DIM) begin
      kh_eff = KCW'(MAX_KERNEL_DIM);
    end else begin
      kh_eff = KCW'(kernel_height_r);
    end
  end

  // Configuration writes are never held off; unknown indexes do nothing.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r   <= zpconv_pkg::RST_IMAGE_WIDTH;
      image_height_r  <= zpconv_pkg::RST_IMAGE_HEIGHT;
      kernel_width_r  <= zpconv_pkg::RST_KERNEL_WIDTH;
      kernel_height_r <= zpconv_pkg::RST_KERNEL_HEIGHT;
      kernel_frac_r   <= zpconv_pkg::RST_KERNEL_FRAC;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        zpconv_pkg::REG_IMAGE_WIDTH: begin
          image_width_r <= cfg_data[zpconv_pkg::CFG_DIM_W-1:0];
        end
        zpconv_pkg::REG_IMAGE_HEIGHT: begin
          image_height_r <= cfg_data[zpconv_pkg::CFG_DIM_W-1:0];
        end
        zpconv_pkg::REG_KERNEL_WIDTH: begin
          kernel_width_r <= cfg_data[zpconv_pkg::CFG_KDIM_W-1:0];
        end
        zpconv_pkg::REG_KERNEL_HEIGHT: begin
          kernel_height_r <= cfg_data[zpconv_pkg::CFG_KDIM_W-1:0];
        end
        zpconv_pkg::REG_KERNEL_FRAC: begin
          kernel_frac_r <= cfg_data[zpconv_pkg::CFG_FRAC_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Request decode. Writes go straight into the stores at the accepting
  // edge; the sample is taken from the low bits of the value field.
  assign accept       = start && !busy;
  assign is_compute   = (in_data.kind == zpconv_pkg::KIND_COMPUTE);
  assign query_inside = (int'(in_data.col) < int'(iw_eff)) &&
                        (int'(in_data.row) < int'(ih_eff));
  assign ker_we       = accept && (in_data.kind == zpconv_pkg::KIND_KERNEL) &&
                        (int'(in_data.col) < int'(kw_eff)) &&
                        (int'(in_data.row) < int'(kh_eff));
  assign img_we       = accept && (in_data.kind == zpconv_pkg::KIND_IMAGE) && query_inside;
  assign wr_sample    = SAMPLE_BITS'(32'($unsigned(in_data.value)));
  assign ker_waddr    = KAW'(KAW'(in_data.row) * KAW'(MAX_KERNEL_DIM) + KAW'(in_data.col));
  assign img_waddr    = IAW'(IAW'(in_data.row) * IAW'(MAX_IMAGE_DIM) + IAW'(in_data.col));

  // Image position of the tap being issued, and whether it lies inside.
  always_comb begin
    tap_x = $signed(XW'(q_col_r)) + $signed(XW'(tap_l_r)) - $signed(XW'(kw_eff >> 1));
    tap_y = $signed(XW'(q_row_r)) + $signed(XW'(tap_k_r)) - $signed(XW'(kh_eff >> 1));
    tap_inside = (tap_x >= 0) && (tap_x < $signed(XW'(iw_eff))) &&
                 (tap_y >= 0) && (tap_y < $signed(XW'(ih_eff)));
    img_raddr = IAW'(IAW'(tap_y[XW-2:0]) * IAW'(MAX_IMAGE_DIM) + IAW'(tap_x[XW-2:0]));
    ker_raddr = KAW'(KAW'(tap_k_r) * KAW'(MAX_KERNEL_DIM) + KAW'(tap_l_r));
    last_tap  = (tap_l_r == kw_eff - KCW'(1)) && (tap_k_r == kh_eff - KCW'(1));
  end

  zpconv_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (IDEPTH)
  ) u_image_ram (
    .clk   (clk),
    .we    (img_we),
    .waddr (img_waddr),
    .wdata (wr_sample),
    .raddr (img_raddr),
    .rdata (img_rdata)
  );

  zpconv_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (KDEPTH)
  ) u_kernel_ram (
    .clk   (clk),
    .we    (ker_we),
    .waddr (ker_waddr),
    .wdata (wr_sample),
    .raddr (ker_raddr),
    .rdata (ker_rdata)
  );

  // Sequencer: next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      zpconv_pkg::ST_IDLE: begin
        if (accept && is_compute && query_inside) begin
          state_nxt = zpconv_pkg::ST_RUN;
        end
      end
      zpconv_pkg::ST_RUN: begin
        if (last_tap) begin
          state_nxt = zpconv_pkg::ST_FLUSH0;
        end
      end
      zpconv_pkg::ST_FLUSH0: begin
        state_nxt = zpconv_pkg::ST_FLUSH1;
      end
      zpconv_pkg::ST_FLUSH1: begin
        state_nxt = zpconv_pkg::ST_SCALE;
      end
      zpconv_pkg::ST_SCALE: begin
        state_nxt = zpconv_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = zpconv_pkg::ST_IDLE;
      end
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    busy        = 1'b1;
    tap_issue   = 1'b0;
    load_result = 1'b0;
    case (state_r)
      zpconv_pkg::ST_IDLE: begin
        busy = 1'b0;
      end
      zpconv_pkg::ST_RUN: begin
        tap_issue = 1'b1;
      end
      zpconv_pkg::ST_SCALE: begin
        load_result = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Tap counters: column runs fastest, as in the row-major sweep.
  always_comb begin
    tap_l_nxt = tap_l_r;
    tap_k_nxt = tap_k_r;
    if (accept) begin
      tap_l_nxt = '0;
      tap_k_nxt = '0;
    end else if (tap_issue) begin
      if (tap_l_r == kw_eff - KCW'(1)) begin
        tap_l_nxt = '0;
        tap_k_nxt = tap_k_r + KCW'(1);
      end else begin
        tap_l_nxt = tap_l_r + KCW'(1);
      end
    end
  end

  // Saturating accumulate of the registered product.
  always_comb begin
    prod_ext = AW'(prod_r);
    sum      = acc_r + prod_ext;
    sum_ovf  = (acc_r[AW-1] == prod_ext[AW-1]) && (sum[AW-1] != acc_r[AW-1]);
    acc_nxt  = acc_r;
    if (accept) begin
      acc_nxt = '0;
    end else if (prod_valid_r) begin
      if (sum_ovf) begin
        acc_nxt = acc_r[AW-1] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
      end else begin
        acc_nxt = sum;
      end
    end
  end

  // Scaling shift rounds toward minus infinity, then clips to 32 bits.
  always_comb begin
    scaled      = acc_r >>> kernel_frac_r;
    scaled_fits = (&scaled[AW-1:QW-1]) || !(|scaled[AW-1:QW-1]);
    out_data_nxt = out_data_r;
    if (load_result) begin
      out_data_nxt.out_col = q_col_r;
      out_data_nxt.out_row = q_row_r;
      if (scaled_fits) begin
        out_data_nxt.pixel_out = scaled[QW-1:0];
        out_data_nxt.saturated = 1'b0;
      end else begin
        out_data_nxt.pixel_out = scaled[AW-1] ? {1'b1, {(QW-1){1'b0}}}
                                              : {1'b0, {(QW-1){1'b1}}};
        out_data_nxt.saturated = 1'b1;
      end
    end else if (accept && is_compute) begin
      // A compute query loads its coordinates and a zero pixel; for a query outside the image this is its answer.
      out_data_nxt.out_col   = in_data.col;
      out_data_nxt.out_row   = in_data.row;
      out_data_nxt.pixel_out = '0;
      out_data_nxt.saturated = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= zpconv_pkg::ST_IDLE;
      tap_l_r      <= '0;
      tap_k_r      <= '0;
      rd_valid_r   <= 1'b0;
      prod_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      tap_l_r      <= tap_l_nxt;
      tap_k_r      <= tap_k_nxt;
      rd_valid_r   <= tap_issue && tap_inside;
      prod_valid_r <= rd_valid_r;
      out_valid_r  <= load_result || (accept && is_compute && !query_inside);
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      q_col_r <= in_data.col;
      q_row_r <= in_data.row;
    end
    prod_r     <= $signed(img_rdata) * $signed(ker_rdata);
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- hw/rtl/zpconv_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module zpconv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
